// File: sv/pbsd_pkg.sv
package pbsd_pkg;

  localparam logic [2:0]  SLOTS_BRIDGE = 3'd2;
  localparam logic [2:0]  SLOTS_DEVICE = 3'd6;
  localparam logic [2:0]  SLOT_MAX     = 3'd7;

  localparam logic [31:0] ALL_ONES32   = 32'hFFFF_FFFF;
  localparam logic [63:0] IO_MASK      = 64'h0000_0000_0000_FFFC;
  localparam logic [31:0] MEM32_MASK   = 32'hFFFF_FFF0;
  localparam logic [63:0] MEM64_MASK   = 64'hFFFF_FFFF_FFFF_FFF0;
  localparam int unsigned IO_BIT       = 0;
  localparam int unsigned MEM64_BIT    = 2;

  typedef enum logic [1:0] {
    KIND_IO    = 2'd0,
    KIND_MEM32 = 2'd1,
    KIND_MEM64 = 2'd2
  } space_kind_t;

  typedef struct packed {
    logic        first_of_device;
    logic        bridge_header;
    logic [31:0] bar_value;
    logic [31:0] sized_value;
  } item_t;

  // decoded slot, before the span is worked out
  typedef struct packed {
    logic        emit;
    logic [2:0]  slot;
    space_kind_t kind;
    logic [63:0] base;
    logic [63:0] size;
    logic [63:0] mask;
  } dec_t;

endpackage

// File: sv/pbsd_in_if.sv
interface pbsd_in_if;
  logic        valid;
  logic        ready;
  logic        first_of_device;
  logic        bridge_header;
  logic [31:0] bar_value;
  logic [31:0] sized_value;

  modport source (output valid, first_of_device, bridge_header, bar_value, sized_value,
                  input ready);
  modport sink   (input valid, first_of_device, bridge_header, bar_value, sized_value,
                  output ready);
endinterface

// File: sv/pbsd_out_if.sv
interface pbsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot_index;
  logic [1:0]  space_kind;
  logic [63:0] region_base;
  logic [63:0] region_span;
  logic        region_valid;

  modport source (output valid, slot_index, space_kind, region_base, region_span,
                  region_valid, input ready);
  modport sink   (input valid, slot_index, space_kind, region_base, region_span,
                  region_valid, output ready);
endinterface

// File: sv/pbsd_slot_tracker.sv
module pbsd_slot_tracker import pbsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  output dec_t  dec
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic        bmode_r, bmode_nxt;
  logic        pend_r, pend_nxt;
  logic [27:0] held_base_r, held_base_nxt;
  logic [27:0] held_size_r, held_size_nxt;

  logic [2:0]  cnt_eff;
  logic [2:0]  cnt_inc;
  logic [2:0]  slot_count;
  logic        pend_eff;
  logic [31:0] bar_c;
  logic [31:0] sized_c;

  always_comb begin
    cnt_eff    = item.first_of_device ? 3'd0 : cnt_r;
    pend_eff   = item.first_of_device ? 1'b0 : pend_r;
    bmode_nxt  = item.first_of_device ? item.bridge_header : bmode_r;
    slot_count = bmode_nxt ? SLOTS_BRIDGE : SLOTS_DEVICE;
    cnt_inc    = (cnt_eff == SLOT_MAX) ? SLOT_MAX : cnt_eff + 3'd1;

    // all-ones readings of the low dword mean nothing there
    bar_c   = (item.bar_value == ALL_ONES32) ? 32'd0 : item.bar_value;
    sized_c = (item.sized_value == ALL_ONES32) ? 32'd0 : item.sized_value;

    cnt_nxt       = cnt_eff;
    pend_nxt      = 1'b0;
    held_base_nxt = held_base_r;
    held_size_nxt = held_size_r;

    dec.emit = 1'b0;
    dec.slot = cnt_eff;
    dec.kind = KIND_MEM32;
    dec.base = {32'd0, bar_c & MEM32_MASK};
    dec.size = {32'd0, sized_c & MEM32_MASK};
    dec.mask = {32'd0, MEM32_MASK};

    if (pend_eff) begin
      // upper half always taken, even past the slot count
      cnt_nxt  = cnt_inc;
      dec.emit = 1'b1;
      dec.kind = KIND_MEM64;
      dec.base = {item.bar_value, held_base_r, 4'd0};
      dec.size = {item.sized_value, held_size_r, 4'd0};
      dec.mask = MEM64_MASK;
    end else if (cnt_eff < slot_count) begin
      cnt_nxt = cnt_inc;
      if (bar_c[IO_BIT]) begin
        dec.emit = 1'b1;
        dec.kind = KIND_IO;
        dec.base = {32'd0, bar_c} & IO_MASK;
        dec.size = {32'd0, sized_c};
        dec.mask = IO_MASK;
      end else if (bar_c[MEM64_BIT]) begin
        pend_nxt      = 1'b1;
        held_base_nxt = bar_c[31:4];
        held_size_nxt = sized_c[31:4];
      end else begin
        dec.emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      bmode_r     <= 1'b0;
      pend_r      <= 1'b0;
      held_base_r <= 28'd0;
      held_size_r <= 28'd0;
    end else if (step) begin
      cnt_r       <= cnt_nxt;
      bmode_r     <= bmode_nxt;
      pend_r      <= pend_nxt;
      held_base_r <= held_base_nxt;
      held_size_r <= held_size_nxt;
    end
  end

  // a held low half always sits inside the slot count
  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (cnt_r <= SLOTS_DEVICE) && (!bmode_r || cnt_r <= SLOTS_BRIDGE))
    else $error("pending low half beyond slot count");

  // a new function may itself start with a 64-bit low half
  a_pend_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    step && pend_r && !item.first_of_device |=> !pend_r)
    else $error("upper half did not clear pending flag");

  a_emit_64_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    dec.emit && dec.kind == KIND_MEM64 |-> pend_r && !item.first_of_device)
    else $error("64-bit region without held low half");

endmodule

// File: sv/pbsd_region_calc.sv
module pbsd_region_calc import pbsd_pkg::*; (
  input  dec_t        dec,
  output logic [63:0] span,
  output logic        region_valid
);

  logic [63:0] s;
  logic [63:0] low_span;
  logic        refuse;

  always_comb begin
    s        = dec.mask & dec.size;
    // bits below the lowest set bit of s
    low_span = (s - 64'd1) & ~s;
    refuse   = (dec.base == dec.size) && (((dec.base | low_span) & dec.mask) != dec.mask);
    span     = ((s == 64'd0) || refuse) ? 64'd0 : low_span;
    region_valid = (dec.base != 64'd0) && (span != 64'd0);
  end

endmodule

// File: sv/pci_bar_size_decoder.sv
// PCI base address register sizing decoder. Each input transaction carries one slot of a
// function (original dword, dword read back after sizing, bridge flag); a result gives the
// slot number, space kind, masked base and span. A 64-bit memory slot takes two
// transactions and reports once, on the upper one. One transaction is taken every clock
// cycle while the output is not stalled; a result passes the input register, then the
// result register, and waits there until taken, with the slot state updated as a
// transaction leaves the input register. Transactions beyond the slot count (but for the
// upper half of a 64-bit slot) and low halves of 64-bit slots give no result.
module pci_bar_size_decoder import pbsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pbsd_in_if.sink   in_item,
  pbsd_out_if.source out_item
);

  item_t       a_item_r;
  logic        a_valid_r;
  logic        advance;
  dec_t        dec;
  logic [63:0] span;
  logic        region_valid;

  logic        out_valid_r;
  logic [2:0]  out_slot_r;
  space_kind_t out_kind_r;
  logic [63:0] out_base_r;
  logic [63:0] out_span_r;
  logic        out_region_valid_r;

  assign advance       = !out_valid_r || out_item.ready;
  assign in_item.ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      a_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.ready && in_item.valid) begin
      a_item_r <= '{first_of_device: in_item.first_of_device,
                    bridge_header:   in_item.bridge_header,
                    bar_value:       in_item.bar_value,
                    sized_value:     in_item.sized_value};
    end
  end

  pbsd_slot_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (a_valid_r && advance),
    .item  (a_item_r),
    .dec   (dec)
  );

  pbsd_region_calc u_calc (
    .dec          (dec),
    .span         (span),
    .region_valid (region_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= a_valid_r && dec.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid_r && dec.emit) begin
      out_slot_r         <= dec.slot;
      out_kind_r         <= dec.kind;
      out_base_r         <= dec.base;
      out_span_r         <= span;
      out_region_valid_r <= region_valid;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.slot_index   = out_slot_r;
  assign out_item.space_kind   = out_kind_r;
  assign out_item.region_base  = out_base_r;
  assign out_item.region_span  = out_span_r;
  assign out_item.region_valid = out_region_valid_r;

  // the low half of a 64-bit region always takes a slot first
  a_mem64_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_MEM64 |-> out_slot_r != 3'd0)
    else $error("64-bit region reported on slot zero");

  a_io_base_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_IO |-> out_base_r[63:16] == 48'd0)
    else $error("I/O base wider than port space");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !advance |=> a_valid_r && $stable(a_item_r))
    else $error("input register lost a stalled transaction");

endmodule
